### hw/rtl/ffrp_pkg.sv
// ----------------------------------------------------------------------------
// First-fit row packer package
// Shared widths, transaction payload types, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffrp_pkg;

  localparam int unsigned MaxRowsDef = 16;
  localparam int unsigned FieldW     = 16;
  localparam int unsigned RowIdxOutW = 6;

  typedef struct packed {
    logic [FieldW-1:0] grp_id;
    logic [FieldW-1:0] item_id;
    logic [FieldW-1:0] start_day;
    logic [FieldW-1:0] end_day;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0]     item_out;
    logic [RowIdxOutW-1:0] row_index;
    logic                  opened_row;
    logic                  overflow;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } ffrp_state_e;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

### hw/rtl/ffrp_if.sv
// ----------------------------------------------------------------------------
// First-fit row packer channels
// Valid/ready channels for input intervals and for placement results.
// ----------------------------------------------------------------------------
interface ffrp_in_if import ffrp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffrp_out_if import ffrp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ffrp_ctrl.sv
// ----------------------------------------------------------------------------
// First-fit row packer controller
// Takes one input transaction, then commits its placement as soon as the
// result register is free.
// ----------------------------------------------------------------------------
module ffrp_ctrl import ffrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ffrp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!status_i.out_blocked) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.commit = !status_i.out_blocked;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/ffrp_dp.sv
// ----------------------------------------------------------------------------
// First-fit row packer datapath
// Holds the last interval of each row, compares all open rows side by side,
// picks the lowest row that fits and registers the result.
// ----------------------------------------------------------------------------
module ffrp_dp import ffrp_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  localparam int unsigned RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned UsedW = $clog2(MAX_ROWS + 1);

  in_item_t          in_q;
  logic [FieldW-1:0] row_start_q [MAX_ROWS];
  logic [FieldW-1:0] row_end_q   [MAX_ROWS];
  logic [UsedW-1:0]  rows_used_q, rows_used_d;
  logic [FieldW-1:0] group_q;
  logic              seen_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic                new_group;
  logic [UsedW-1:0]    used_eff;
  logic [MAX_ROWS-1:0] fit;
  logic [MAX_ROWS-1:0] wr_en;
  logic [RowW-1:0]     pick;
  logic                found;
  logic                room;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    new_group = !seen_q || (in_q.grp_id != group_q);
    used_eff  = new_group ? '0 : rows_used_q;
    room      = used_eff < UsedW'(MAX_ROWS);
    for (int i = 0; i < MAX_ROWS; i++) begin
      fit[i] = (UsedW'(i) < used_eff) &&
               !((in_q.start_day < row_end_q[i]) && (row_start_q[i] < in_q.end_day));
    end
    found = |fit;
    pick  = '0;
    for (int i = MAX_ROWS - 1; i >= 0; i--) begin
      if (fit[i]) begin
        pick = RowW'(i);
      end
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      wr_en[i] = found ? (pick == RowW'(i)) : (room && (used_eff == UsedW'(i)));
    end
  end

  always_comb begin
    rows_used_d         = used_eff;
    out_d.item_out      = in_q.item_id;
    out_d.row_index     = '0;
    out_d.opened_row    = 1'b0;
    out_d.overflow      = 1'b0;
    if (found) begin
      out_d.row_index = RowIdxOutW'(pick);
    end else if (room) begin
      out_d.row_index  = RowIdxOutW'(used_eff);
      out_d.opened_row = 1'b1;
      rows_used_d      = used_eff + UsedW'(1);
    end else begin
      out_d.overflow = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (cmd_i.commit && wr_en[i]) begin
        row_start_q[i] <= in_q.start_day;
        row_end_q[i]   <= in_q.end_day;
      end
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= '0;
      group_q     <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        rows_used_q <= rows_used_d;
        group_q     <= in_q.grp_id;
        seen_q      <= 1'b1;
      end
    end
  end

  assign status_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;

`ifndef SYNTHESIS
  a_rows_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_used_q <= UsedW'(MAX_ROWS))
    else $error("Open row count exceeds the row capacity.");

  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.overflow) |-> (!out_q.opened_row && (out_q.row_index == '0)))
    else $error("Overflow result carries a row or an opened flag.");

  a_open_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !found && room) |=> (rows_used_q == $past(used_eff) + UsedW'(1)))
    else $error("Opening a row did not advance the open row count.");

  a_commit_frees_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("Commit overwrote a result that was not taken.");
`endif

endmodule

### hw/rtl/first_fit_interval_row_packer.sv
// An accepted input is captured in the input register, evaluated and written to the
// output register; the write waits while an earlier result waits at the output.
// A new interval is taken only after the last one is committed; the row compare and
// first-fit pick for all open rows run in the evaluation state.
// Reset clears the row count, the group tracking and the output valid flag;
// the row start and end stores are not reset and are read only once written.
// ----------------------------------------------------------------------------
// First-fit interval row packer
// Assigns each interval to the lowest row whose last interval does not overlap
// it, opens new rows as needed, starts anew per group, flags overflow when full.
// ----------------------------------------------------------------------------
module first_fit_interval_row_packer import ffrp_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffrp_in_if.sink     in_i,
  ffrp_out_if.source  out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ffrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ffrp_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
